// ===== design/mlr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the midpoint line rasterizer: the opcode carried in the input tuser.
// No dependencies; the top level and the checker import it.
package mlr_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } mlr_op_t;

endpackage

// ===== design/midpoint_line_rasterizer.sv =====
`timescale 1ns / 1ps
// Midpoint line rasterizer, all octants. A stepped pixel is registered in the output
// register, or in the skid stage while the output stalls. Throughput: one input transfer
// per cycle while the skid stage is empty; the midpoint update (one compare and two adds
// on the decision term) sits between the walk state registers and the output register.
// A skid stage keeps in_tready high for one extra result while the output stalls. Reset
// (rst_n low, synchronous) drops any loaded line and empties both output stages.
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = 11
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // Input channel.
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // From bit 0 up: start_x, start_y, end_x, end_y, then zero padding.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]            in_tdata,
  // Bit 0: opcode (load endpoints or step).
  input  mlr_pkg::mlr_op_t                             in_tuser,
  // Result channel.
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // From bit 0 up: pixel_x, pixel_y, then zero padding.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]            out_tdata,
  // last_pixel.
  output logic                                         out_tlast
);
  import mlr_pkg::*;

  localparam int N    = COORD_BITS;
  localparam int W    = COORD_BITS + 1;   // walk coordinates, x may be mirrored
  localparam int DW   = COORD_BITS + 3;   // decision term
  localparam int ITW  = ((4*COORD_BITS+7)/8)*8;
  localparam int OTW  = ((2*COORD_BITS+7)/8)*8;

  // Walk state.
  logic signed [W-1:0]  walk_x_r, walk_y_r, stop_coord_r;
  logic        [N-1:0]  delta_x_r, delta_y_r;
  logic signed [DW-1:0] decision_r;
  logic                 mirrored_r, x_major_r, first_pending_r, active_r;

  // Output register and skid stage.
  logic                 out_valid_r, skid_valid_r;
  logic [N-1:0]         out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic                 out_last_r, skid_last_r;

  logic                 in_xfer, do_load, do_step;

  assign in_tready = !skid_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign do_load   = in_xfer && (in_tuser == OP_LOAD);
  assign do_step   = in_xfer && (in_tuser == OP_STEP) && active_r;

  // Load setup: sign-extend the endpoints to walk width and work out the octant.
  logic signed [W-1:0]  ax, ay, bx, by, ax_m, bx_m, ddx, ddy, abs_dx, abs_dy;
  logic        [N-1:0]  ld_dx, ld_dy;
  logic                 ld_mirror, ld_xmaj, ld_swap;
  logic signed [W-1:0]  ld_wx, ld_wy, ld_stop;
  logic signed [DW-1:0] ld_dec;

  always_comb begin
    ax = W'(signed'(in_tdata[N-1:0]));
    ay = W'(signed'(in_tdata[2*N-1:N]));
    bx = W'(signed'(in_tdata[3*N-1:2*N]));
    by = W'(signed'(in_tdata[4*N-1:3*N]));
    ddx = ax - bx;
    ddy = ay - by;
    abs_dx = ddx[W-1] ? -ddx : ddx;
    abs_dy = ddy[W-1] ? -ddy : ddy;
    ld_dx = abs_dx[N-1:0];
    ld_dy = abs_dy[N-1:0];
    // A negative slope is walked with x mirrored so the minor axis always rises.
    ld_mirror = (ddx != '0) && (ddy != '0) && (ddx[W-1] != ddy[W-1]);
    ax_m = ld_mirror ? -ax : ax;
    bx_m = ld_mirror ? -bx : bx;
    ld_xmaj = (ld_dx != '0) && (ld_dy <= ld_dx);
    if (ld_xmaj) begin
      ld_dec  = DW'({ld_dy, 1'b0}) - DW'(ld_dx);
      ld_swap = ax_m > bx_m;
    end else begin
      ld_dec  = DW'({ld_dx, 1'b0}) - DW'(ld_dy);
      ld_swap = ay > by;
    end
    // Start at the endpoint that is lower along the major axis.
    ld_wx = ld_swap ? bx_m : ax_m;
    ld_wy = ld_swap ? by : ay;
    if (ld_xmaj) begin
      ld_stop = ld_swap ? ax_m : bx_m;
    end else begin
      ld_stop = ld_swap ? ay : by;
    end
  end

  // One midpoint step; the first pixel of a line is emitted without stepping.
  logic signed [W-1:0]  st_wx, st_wy, neg_x;
  logic signed [DW-1:0] st_dec, two_dx, two_dy;
  logic                 st_done;
  logic [N-1:0]         st_px;

  always_comb begin
    two_dx = DW'({delta_x_r, 1'b0});
    two_dy = DW'({delta_y_r, 1'b0});
    st_wx  = walk_x_r;
    st_wy  = walk_y_r;
    st_dec = decision_r;
    if (!first_pending_r) begin
      if (x_major_r) begin
        st_wx = walk_x_r + W'(1);
        if (decision_r[DW-1]) begin
          st_dec = decision_r + two_dy;
        end else begin
          st_wy  = walk_y_r + W'(1);
          st_dec = decision_r + two_dy - two_dx;
        end
      end else begin
        st_wy = walk_y_r + W'(1);
        if (decision_r[DW-1]) begin
          st_dec = decision_r + two_dx;
        end else begin
          st_wx  = walk_x_r + W'(1);
          st_dec = decision_r + two_dx - two_dy;
        end
      end
    end
    st_done = x_major_r ? (st_wx >= stop_coord_r) : (st_wy >= stop_coord_r);
    neg_x   = -st_wx;
    st_px   = mirrored_r ? neg_x[N-1:0] : st_wx[N-1:0];
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_x_r        <= '0;
      walk_y_r        <= '0;
      stop_coord_r    <= '0;
      delta_x_r       <= '0;
      delta_y_r       <= '0;
      decision_r      <= '0;
      mirrored_r      <= 1'b0;
      x_major_r       <= 1'b0;
      first_pending_r <= 1'b0;
      active_r        <= 1'b0;
    end else if (do_load) begin
      walk_x_r        <= ld_wx;
      walk_y_r        <= ld_wy;
      stop_coord_r    <= ld_stop;
      delta_x_r       <= ld_dx;
      delta_y_r       <= ld_dy;
      decision_r      <= ld_dec;
      mirrored_r      <= ld_mirror;
      x_major_r       <= ld_xmaj;
      first_pending_r <= 1'b1;
      active_r        <= 1'b1;
    end else if (do_step) begin
      walk_x_r        <= st_wx;
      walk_y_r        <= st_wy;
      decision_r      <= st_dec;
      first_pending_r <= 1'b0;
      active_r        <= !st_done;
    end
  end

  // Output register with a skid stage. New pixels go to the output register when it
  // is free or being drained, otherwise they park in the skid stage, which then
  // holds off the input until it moves forward.
  logic out_drain;
  assign out_drain = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_drain) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (do_step) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_drain) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_drain) begin
        out_x_r    <= skid_x_r;
        out_y_r    <= skid_y_r;
        out_last_r <= skid_last_r;
      end
    end else if (do_step) begin
      if (!out_valid_r || out_tready) begin
        out_x_r    <= st_px;
        out_y_r    <= st_wy[N-1:0];
        out_last_r <= st_done;
      end else begin
        skid_x_r    <= st_px;
        skid_y_r    <= st_wy[N-1:0];
        skid_last_r <= st_done;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OTW'({out_y_r, out_x_r});
  assign out_tlast  = out_last_r;

  // Input padding bits above the four coordinates carry nothing.
  if (ITW > 4*N) begin : g_pad
    logic unused_pad;
    assign unused_pad = ^in_tdata[ITW-1:4*N];
  end

endmodule

// ===== design/mlr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the midpoint line rasterizer, and the bind that attaches them.
// Depends on mlr_pkg and on the port list of midpoint_line_rasterizer.
module mlr_checker #(
  parameter int COORD_BITS = 11
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input mlr_pkg::mlr_op_t                     in_tuser,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*COORD_BITS+7)/8)*8-1:0]    out_tdata,
  input logic                                 out_tlast
);
  import mlr_pkg::*;

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A load into an idle output side produces no pixel.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_LOAD && !out_tvalid) |=> !out_tvalid)
    else $error("pixel appeared after a load");

  // The input is held off only while a pixel waits at the output.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty output");

  // A stalled pixel holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled pixel changed");

endmodule

bind midpoint_line_rasterizer mlr_checker #(.COORD_BITS(COORD_BITS)) u_mlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
